// File: hdl/mmss_pkg.sv
// Shared definitions for the merged-mining slot search core.
// Holds the LCG constants and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package mmss_pkg;

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;

    typedef struct packed {
        logic store_id;
        logic search_clear;
        logic lg_inc;
        logic nonce_clear;
        logic nonce_inc;
        logic trial_init;
        logic check;
        logic emit_ok;
        logic emit_fail;
    } mmss_cmd_t;

    typedef struct packed {
        logic lg_at_limit;
        logic size_short;
        logic collision;
        logic k_last;
        logic nonce_last;
        logic lg_last;
        logic out_free;
    } mmss_status_t;

endpackage

`default_nettype wire

// File: hdl/mmss_ctrl.sv
// Controller state machine for the merged-mining slot search core.
// Sequences loading, tree sizing, nonce trials and result emission; depends on mmss_pkg.
`default_nettype none

module mmss_ctrl
    import mmss_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tlast,
    output logic              s_tready,
    input  mmss_status_t      status,
    output mmss_cmd_t         cmd
);

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_SIZE  = 7'b0000010,
        S_INIT  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_NEXT  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_FAIL  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_LOAD);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD: begin
                if (s_tvalid) begin
                    cmd.store_id = 1'b1;
                    if (s_tlast) begin
                        cmd.search_clear = 1'b1;
                        state_next       = S_SIZE;
                    end
                end
            end
            S_SIZE: begin
                if (status.lg_at_limit) begin
                    state_next = S_FAIL;
                end else if (status.size_short) begin
                    cmd.lg_inc = 1'b1;
                end else begin
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                cmd.trial_init = 1'b1;
                state_next     = S_CHECK;
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (status.collision) begin
                    state_next = S_NEXT;
                end else if (status.k_last) begin
                    state_next = S_EMIT;
                end
            end
            S_NEXT: begin
                if (status.nonce_last) begin
                    if (status.lg_last) begin
                        state_next = S_FAIL;
                    end else begin
                        cmd.lg_inc      = 1'b1;
                        cmd.nonce_clear = 1'b1;
                        state_next      = S_INIT;
                    end
                end else begin
                    cmd.nonce_inc = 1'b1;
                    state_next    = S_INIT;
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_ok = 1'b1;
                    if (status.k_last) begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_FAIL: begin
                if (status.out_free) begin
                    cmd.emit_fail = 1'b1;
                    state_next    = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/mmss_dpath.sv
// Datapath for the merged-mining slot search core: chain store, LCG slot mapper,
// slot compare against earlier chains, slot store and the output register; depends on mmss_pkg.
`default_nettype none

module mmss_dpath
    import mmss_pkg::*;
#(
    parameter int MAX_CHAINS     = 16,
    parameter int TREE_LOG_LIMIT = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  mmss_cmd_t         cmd,
    output mmss_status_t      status,
    input  wire logic [15:0]  chain_id,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [6:0]        slot_index,
    output logic [6:0]        search_nonce,
    output logic [7:0]        tree_slots,
    output logic              found,
    output logic              last_result
);

    localparam int W     = (TREE_LOG_LIMIT > 1) ? TREE_LOG_LIMIT - 1 : 1;
    localparam int KW    = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS) : 1;
    localparam int CW    = $clog2(MAX_CHAINS + 1);
    localparam int LW    = $clog2(TREE_LOG_LIMIT + 1);
    localparam int SW    = TREE_LOG_LIMIT + 1;
    localparam int CMPW  = (SW > CW) ? SW : CW;
    localparam logic [W-1:0] MulW      = LCG_MUL[W-1:0];
    localparam logic [W-1:0] AddW      = LCG_ADD[W-1:0];
    localparam logic [7:0]   FailSlots = 8'((1 << (TREE_LOG_LIMIT - 1)) & 255);

    logic [15:0]     chain_store_reg [MAX_CHAINS];
    logic [W-1:0]    slot_store_reg  [MAX_CHAINS];
    logic [CW-1:0]   count_reg, count_next;
    logic [W-1:0]    nonce_reg, nonce_next;
    logic [LW-1:0]   lg_reg, lg_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [W-1:0]    r_reg;
    logic            m_valid_reg, m_valid_next;
    logic [6:0]      m_slot_reg, m_nonce_reg;
    logic [7:0]      m_tree_reg;
    logic            m_found_reg, m_last_reg;

    logic [CMPW-1:0] size_full;
    logic [W-1:0]    mask;
    logic [W-1:0]    id_w, sum_w, prod_w, slot_w;
    logic [MAX_CHAINS-1:0] hit;
    logic            out_free;
    logic            count_clear;

    assign size_full = {{(CMPW - 1){1'b0}}, 1'b1} << lg_reg;
    assign mask      = W'(size_full - {{(CMPW - 1){1'b0}}, 1'b1});
    assign id_w      = chain_store_reg[k_reg][W-1:0];
    assign sum_w     = r_reg + id_w;
    assign prod_w    = W'(sum_w * MulW);
    assign slot_w    = (prod_w + AddW) & mask;
    assign out_free  = !m_valid_reg || m_tready;
    assign count_clear = cmd.emit_fail || (cmd.emit_ok && status.k_last);

    always_comb begin
        for (int j = 0; j < MAX_CHAINS; j++) begin
            hit[j] = (KW'(j) < k_reg) && (slot_store_reg[j] == slot_w);
        end
    end

    always_comb begin
        status.lg_at_limit = (lg_reg == LW'(TREE_LOG_LIMIT));
        status.size_short  = (size_full < CMPW'(count_reg));
        status.collision   = |hit;
        status.k_last      = ((CW'(k_reg) + CW'(1)) == count_reg);
        status.nonce_last  = (nonce_reg == mask);
        status.lg_last     = (lg_reg == LW'(TREE_LOG_LIMIT - 1));
        status.out_free    = out_free;
    end

    always_comb begin
        count_next   = count_reg;
        nonce_next   = nonce_reg;
        lg_next      = lg_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (cmd.store_id && (count_reg < CW'(MAX_CHAINS))) begin
            count_next = count_reg + CW'(1);
        end
        if (count_clear) begin
            count_next = '0;
        end
        if (cmd.search_clear) begin
            lg_next    = '0;
            nonce_next = '0;
        end
        if (cmd.lg_inc) begin
            lg_next = lg_reg + LW'(1);
        end
        if (cmd.nonce_clear) begin
            nonce_next = '0;
        end
        if (cmd.nonce_inc) begin
            nonce_next = nonce_reg + W'(1);
        end
        if (cmd.trial_init) begin
            k_next = '0;
        end
        if (cmd.check && !status.collision) begin
            k_next = status.k_last ? '0 : k_reg + KW'(1);
        end
        if (cmd.emit_ok) begin
            k_next = k_reg + KW'(1);
        end
        if (cmd.emit_ok || cmd.emit_fail) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            nonce_reg   <= '0;
            lg_reg      <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            nonce_reg   <= nonce_next;
            lg_reg      <= lg_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_id && (count_reg < CW'(MAX_CHAINS))) begin
            chain_store_reg[count_reg[KW-1:0]] <= chain_id;
        end
        if (cmd.trial_init) begin
            r_reg <= W'(nonce_reg * MulW) + AddW;
        end
        if (cmd.check && !status.collision) begin
            slot_store_reg[k_reg] <= slot_w;
        end
        if (cmd.emit_ok) begin
            m_slot_reg  <= 7'(slot_store_reg[k_reg]);
            m_nonce_reg <= 7'(nonce_reg);
            m_tree_reg  <= 8'(size_full);
            m_found_reg <= 1'b1;
            m_last_reg  <= status.k_last;
        end else if (cmd.emit_fail) begin
            m_slot_reg  <= '0;
            m_nonce_reg <= '0;
            m_tree_reg  <= FailSlots;
            m_found_reg <= 1'b0;
            m_last_reg  <= 1'b1;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign slot_index   = m_slot_reg;
    assign search_nonce = m_nonce_reg;
    assign tree_slots   = m_tree_reg;
    assign found        = m_found_reg;
    assign last_result  = m_last_reg;

endmodule

`default_nettype wire

// File: hdl/merged_mining_slot_search_core.sv
// After the last chain, the tree grows until it holds all chains or hits its limit;
// each nonce trial then runs setup, one chain per cycle through the LCG mapper, and
// advance on a collision; then the N result items go out at one per cycle while
// m_tready is high. Worst case about 255 trials. One set is searched at a time.
// Reset: aresetn synchronous, active low; clears the chain count and output valid.
`default_nettype none

module merged_mining_slot_search_core
    import mmss_pkg::*;
#(
    parameter int MAX_CHAINS     = 16,
    parameter int TREE_LOG_LIMIT = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // [15:0] chain_id
    input  wire logic         s_tlast,   // last_chain
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [23:0]       m_tdata,   // [6:0] slot_index, [13:7] search_nonce,
                                         // [21:14] tree_slots, [23:22] zero
    output logic              m_tuser,   // found
    output logic              m_tlast    // last_result
);

    mmss_cmd_t    cmd;
    mmss_status_t status;
    logic [6:0]   slot_index;
    logic [6:0]   search_nonce;
    logic [7:0]   tree_slots;

    mmss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mmss_dpath #(
        .MAX_CHAINS     (MAX_CHAINS),
        .TREE_LOG_LIMIT (TREE_LOG_LIMIT)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .chain_id     (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .slot_index   (slot_index),
        .search_nonce (search_nonce),
        .tree_slots   (tree_slots),
        .found        (m_tuser),
        .last_result  (m_tlast)
    );

    assign m_tdata = {2'b00, tree_slots, search_nonce, slot_index};

endmodule

`default_nettype wire

// File: hdl/mmss_chk.sv
// Port-level checker for merged_mining_slot_search_core, attached by bind.
// Depends only on the top-level ports.
`default_nettype none

module mmss_chk (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         s_tlast,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [23:0]  m_tdata,
    input wire logic         m_tuser,
    input wire logic         m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    a_fail_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata[13:0] == 14'd0))
        else $error("failure item not single and zeroed");

    a_tree_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[21:14]))
        else $error("tree size not a power of two");

    a_search_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during search");

endmodule

bind merged_mining_slot_search_core mmss_chk u_mmss_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: dv/merged_mining_slot_search_core_test.sv
// Self-checking testbench for merged_mining_slot_search_core: streams chain id sets in,
// predicts the LCG slot search per set, and checks every result item field by field.
// Depends on mmss_pkg (LCG constants) and the core RTL.
`timescale 1ns / 100ps

module merged_mining_slot_search_core_test;
    import mmss_pkg::LCG_MUL;
    import mmss_pkg::LCG_ADD;

    localparam int MAX_HELD     = 16;
    localparam int TREE_LOG_LIM = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 30000;
    localparam int RANDOM_ITEMS = 310;

    typedef struct packed {
        logic [6:0] slot;
        logic [6:0] nonce;
        logic [7:0] tree_slots;
        logic       found;
        logic       last;
    } slot_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'h0000;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    slot_result_t pending_slots[$];
    slot_result_t want;
    logic [15:0]  held_ids[MAX_HELD];
    logic [15:0]  chain_set[$];
    int           held_count      = 0;
    int           errors          = 0;
    int           items_sent      = 0;
    int           results_checked = 0;
    int           sets_searched   = 0;
    int           fail_sets       = 0;
    int           quiet_cycles    = 0;
    bit           steady          = 1'b0;
    bit           hold_req        = 1'b0;

    merged_mining_slot_search_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    function automatic logic [6:0] map_slot(input int unsigned nonce, input logic [15:0] id,
                                            input int lg);
        logic [63:0] mask;
        logic [63:0] r;
        mask = (64'd1 << lg) - 64'd1;
        r = (64'(nonce) * 64'(LCG_MUL) + 64'(LCG_ADD)) & mask;
        r = ((r + 64'(id)) * 64'(LCG_MUL) + 64'(LCG_ADD)) & mask;
        return r[6:0];
    endfunction

    function automatic void predict_chain(input logic [15:0] id, input logic last);
        logic       taken[128];
        logic [6:0] slots[MAX_HELD];
        logic [6:0] s;
        int         lg;
        int         nonce;
        int         k;
        int         win_lg;
        int         win_nonce;
        bit         ok;
        bit         clash;
        if (held_count < MAX_HELD) begin
            held_ids[held_count] = id;
            held_count++;
        end
        if (!last)
            return;
        lg = 0;
        while (lg < TREE_LOG_LIM && (1 << lg) < held_count)
            lg++;
        ok        = 1'b0;
        win_lg    = 0;
        win_nonce = 0;
        for (; lg < TREE_LOG_LIM && !ok; lg++) begin
            for (nonce = 0; nonce < (1 << lg) && !ok; nonce++) begin
                foreach (taken[i])
                    taken[i] = 1'b0;
                clash = 1'b0;
                for (k = 0; k < held_count && !clash; k++) begin
                    s = map_slot(nonce, held_ids[k], lg);
                    if (taken[s]) begin
                        clash = 1'b1;
                    end else begin
                        taken[s] = 1'b1;
                        slots[k] = s;
                    end
                end
                if (!clash) begin
                    ok        = 1'b1;
                    win_lg    = lg;
                    win_nonce = nonce;
                end
            end
        end
        sets_searched++;
        if (!ok) begin
            fail_sets++;
            pending_slots.push_back('{slot: 7'd0, nonce: 7'd0, tree_slots: 8'd128,
                                      found: 1'b0, last: 1'b1});
        end else begin
            for (k = 0; k < held_count; k++)
                pending_slots.push_back('{slot: slots[k], nonce: win_nonce[6:0],
                                          tree_slots: 8'(1 << win_lg), found: 1'b1,
                                          last: (k == held_count - 1)});
        end
        held_count = 0;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (pending_slots.size() == 0) begin
                errors++;
                $error("result item with nothing expected: tdata %h user %b last %b",
                       m_tdata, m_tuser, m_tlast);
            end else begin
                want = pending_slots.pop_front();
                if (m_tdata[6:0] !== want.slot) begin
                    errors++;
                    $error("slot_index: expected %0d, got %0d", want.slot, m_tdata[6:0]);
                end
                if (m_tdata[13:7] !== want.nonce) begin
                    errors++;
                    $error("search_nonce: expected %0d, got %0d", want.nonce, m_tdata[13:7]);
                end
                if (m_tdata[21:14] !== want.tree_slots) begin
                    errors++;
                    $error("tree_slots: expected %0d, got %0d", want.tree_slots,
                           m_tdata[21:14]);
                end
                if (m_tdata[23:22] !== 2'b00) begin
                    errors++;
                    $error("tdata pad: expected 0, got %0d", m_tdata[23:22]);
                end
                if (m_tuser !== want.found) begin
                    errors++;
                    $error("found: expected %b, got %b", want.found, m_tuser);
                end
                if (m_tlast !== want.last) begin
                    errors++;
                    $error("last_result: expected %b, got %b", want.last, m_tlast);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready)
            predict_chain(s_tdata, s_tlast);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall    = hold_req ? HOLD_CYCLES : (steady ? 0 : $urandom_range(0, 5));
            hold_req = 1'b0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid && !hold_req);
        end
    end

    task automatic send_chain(input logic [15:0] id, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= id;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_set();
        for (int i = 0; i < chain_set.size(); i++)
            send_chain(chain_set[i], i == chain_set.size() - 1);
    endtask

    task automatic test_small_sets();
        chain_set = '{16'h0000};
        send_set();
        chain_set = '{16'hFFFF, 16'h0000};
        send_set();
    endtask

    // ids equal in their low 7 bits land in the same slot at every size
    task automatic test_shared_slot_failure();
        chain_set = '{16'h1234, 16'h1234};
        send_set();
        chain_set = '{16'h0005, 16'h8005, 16'h0085};
        send_set();
    endtask

    // the final item arrives with the store full and is dropped
    task automatic test_store_overflow();
        chain_set.delete();
        repeat (MAX_HELD + 1)
            chain_set.push_back(16'($urandom));
        send_set();
    endtask

    task automatic test_backpressure();
        steady   = 1'b1;
        hold_req = 1'b1;
        repeat (4) begin
            chain_set.delete();
            repeat (3)
                chain_set.push_back(16'($urandom));
            send_set();
        end
        steady = 1'b0;
    endtask

    task automatic test_random_sets();
        int start;
        int n;
        int kind;
        int src;
        int dst;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            kind   = $urandom_range(0, 19);
            steady = ($urandom_range(0, 3) == 0);
            chain_set.delete();
            if (kind < 2)
                n = $urandom_range(MAX_HELD + 1, MAX_HELD + 4);
            else
                n = $urandom_range(1, $urandom_range(1, MAX_HELD));
            repeat (n)
                chain_set.push_back(16'($urandom));
            if (kind >= 2 && kind < 4 && n >= 2) begin
                src = $urandom_range(0, n - 2);
                dst = $urandom_range(src + 1, n - 1);
                chain_set[dst] = chain_set[src] + 16'($urandom_range(0, 511) << 7);
            end
            send_set();
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_small_sets();
        test_shared_slot_failure();
        test_store_overflow();
        test_backpressure();
        test_random_sets();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_slots.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Searched %0d chain sets (%0d without a collision-free map) from %0d items,",
                 sets_searched, fail_sets, items_sent);
        $display("checked %0d result items, %0d mismatches", results_checked, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
